FILE: design/keypad_combination_lock_alarm_macros.svh
// Assertion macros shared by the keypad lock RTL.
// Each macro expects clk and rst_n in the scope of the module that uses it.
`ifndef KEYPAD_COMBINATION_LOCK_ALARM_MACROS_SVH
`define KEYPAD_COMBINATION_LOCK_ALARM_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define KLK_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define KLK_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define KLK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/klk_pkg.sv
// Types, codes and constants for the keypad combination lock.
// No dependencies; used by every module of the block.
`default_nettype none

package klk_pkg;

  // Key codes
  localparam logic [3:0] KEY_LAST_DIGIT = 4'd8;
  localparam logic [3:0] KEY_STAR       = 4'd9;
  localparam logic [3:0] KEY_ZERO       = 4'd10;

  // Glyphs, active high, bit 0 = segment a
  localparam logic [6:0] GLYPH_A = 7'h77;
  localparam logic [6:0] GLYPH_P = 7'h73;
  localparam logic [6:0] GLYPH_U = 7'h3E;
  localparam logic [6:0] GLYPH_L = 7'h38;
  localparam logic [6:0] GLYPH_E = 7'h79;
  localparam logic [6:0] GLYPH_H = 7'h76;
  localparam logic [6:0] GLYPH_BLANK = 7'h00;

  // Motor commands
  localparam logic [1:0] MOT_RELEASE = 2'd0;
  localparam logic [1:0] MOT_PULSE   = 2'd1;
  localparam logic [1:0] MOT_HOLD    = 2'd3;

  // Configuration register indexes
  localparam logic REG_PASS_CODE   = 1'b0;
  localparam logic REG_RETRY_LIMIT = 1'b1;

  localparam logic [15:0] PASS_CODE_RST   = 16'h1234;
  localparam logic [2:0]  RETRY_LIMIT_RST = 3'd3;
  localparam logic [2:0]  RETRY_MAX       = 3'd7;

  localparam int CODE_DIGITS_DEF = 4;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    MODE_UNLOCKED = 2'd0,
    MODE_LOCKED   = 2'd1,
    MODE_ENTRY    = 2'd2,
    MODE_LOCKOUT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_STAR  = 2'd1,
    EV_DIGIT = 2'd2
  } key_ev_t;

  typedef struct packed {
    logic [3:0] key_code;
    logic       door_closed;
  } in_item_t;

  typedef struct packed {
    logic [1:0] motor_cmd;
    logic       siren;
    logic [6:0] display_segments;
    logic [1:0] mode;
    logic [2:0] digits_entered;
    logic [2:0] retries_used;
  } out_item_t;

  // Classified key event handed from front to back
  typedef struct packed {
    key_ev_t    ev;
    logic [3:0] digit;
    logic       door_closed;
  } ev_item_t;

  function automatic logic [6:0] digit_glyph(input logic [3:0] d);
    logic [6:0] g;
    unique case (d)
      4'd0:    g = 7'h3F;
      4'd1:    g = 7'h06;
      4'd2:    g = 7'h5B;
      4'd3:    g = 7'h4F;
      4'd4:    g = 7'h66;
      4'd5:    g = 7'h6D;
      4'd6:    g = 7'h7D;
      4'd7:    g = 7'h07;
      4'd8:    g = 7'h7F;
      4'd9:    g = 7'h6F;
      default: g = GLYPH_BLANK;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

FILE: design/klk_front.sv
// Front end: decodes raw key codes into star / digit / no-key events.
// Depends on klk_pkg.
`default_nettype none

module klk_front (
  input  wire  klk_pkg::in_item_t in_data,
  output klk_pkg::ev_item_t       ev_data
);
  import klk_pkg::*;

  always_comb begin
    ev_data.door_closed = in_data.door_closed;
    ev_data.digit       = 4'd0;
    ev_data.ev          = EV_NONE;
    priority if (in_data.key_code <= KEY_LAST_DIGIT) begin
      ev_data.ev    = EV_DIGIT;
      ev_data.digit = in_data.key_code + 4'd1;
    end else if (in_data.key_code == KEY_ZERO) begin
      ev_data.ev    = EV_DIGIT;
      ev_data.digit = 4'd0;
    end else if (in_data.key_code == KEY_STAR) begin
      ev_data.ev = EV_STAR;
    end else begin
      ev_data.ev = EV_NONE;  // hash and unused codes
    end
  end

endmodule

`default_nettype wire

FILE: design/klk_queue.sv
// Short FIFO of classified events between front and back.
// Depends on klk_pkg.
`default_nettype none

module klk_queue (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  input  wire  klk_pkg::ev_item_t push_data,
  output logic                    full,
  input  wire                     pop,
  output logic                    not_empty,
  output klk_pkg::ev_item_t       pop_data
);
  import klk_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  ev_item_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/klk_back.sv
// Back end: lock controller, configuration registers and output register.
// Depends on klk_pkg and the assertion macro header.
`default_nettype none
`include "keypad_combination_lock_alarm_macros.svh"

module klk_back #(
  parameter int CODE_DIGITS = klk_pkg::CODE_DIGITS_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_we,
  input  wire                     cfg_index,
  input  wire  [15:0]             cfg_wdata,
  input  wire                     ev_valid,
  input  wire  klk_pkg::ev_item_t ev_data,
  output logic                    ev_pop,
  output logic                    out_valid,
  input  wire                     out_ready,
  output klk_pkg::out_item_t      out_data
);
  import klk_pkg::*;

  localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [2:0] CNT_LAST = 3'(CODE_DIGITS - 1);

  logic [15:0] pass_code_r;
  logic [2:0]  retry_limit_r;

  mode_t       mode_r, mode_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [2:0]  retry_r, retry_nxt;
  logic [6:0]  glyph_r, glyph_nxt;
  logic [3:0]  ent_r [CODE_DIGITS];

  logic        out_valid_r;
  out_item_t   out_data_r;

  logic        is_star, is_digit, last_digit, code_ok, lockout_hit, store_digit;
  logic [2:0]  retry_inc;
  logic [31:0] code_ext;
  logic [1:0]  motor;
  logic        siren;
  logic        in_lockout, out_lockout;

  // Pop whenever the output slot is empty or being drained this cycle
  assign ev_pop    = ev_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_star     = (ev_data.ev == EV_STAR);
  assign is_digit    = (ev_data.ev == EV_DIGIT);
  assign last_digit  = is_digit && (cnt_r == CNT_LAST);
  assign retry_inc   = (retry_r < RETRY_MAX) ? retry_r + 3'd1 : retry_r;
  assign lockout_hit = (retry_inc >= retry_limit_r);
  assign code_ext    = {16'd0, pass_code_r};
  assign store_digit = (mode_r == MODE_ENTRY) && is_digit && !last_digit;

  assign in_lockout  = (mode_r == MODE_LOCKOUT);
  assign out_lockout = out_valid_r && (out_data_r.mode == MODE_LOCKOUT);

  // Compare the stored digits plus the one arriving now with the code
  always_comb begin
    code_ok = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (i == CODE_DIGITS - 1) begin
        if (ev_data.digit != code_ext[4*(CODE_DIGITS-1-i) +: 4]) code_ok = 1'b0;
      end else begin
        if (ent_r[i] != code_ext[4*(CODE_DIGITS-1-i) +: 4]) code_ok = 1'b0;
      end
    end
  end

  // Next mode
  always_comb begin
    mode_nxt = mode_r;
    unique case (mode_r)
      MODE_UNLOCKED: begin
        if (is_star && ev_data.door_closed) mode_nxt = MODE_LOCKED;
      end
      MODE_LOCKED: begin
        if (ev_data.door_closed && is_star) mode_nxt = MODE_ENTRY;
      end
      MODE_ENTRY: begin
        if (is_star && cnt_r == 3'd0) begin
          mode_nxt = MODE_LOCKED;
        end else if (last_digit) begin
          if (code_ok)          mode_nxt = MODE_UNLOCKED;
          else if (lockout_hit) mode_nxt = MODE_LOCKOUT;
        end
      end
      MODE_LOCKOUT: mode_nxt = MODE_LOCKOUT;
    endcase
  end

  // Outputs and counters
  always_comb begin
    glyph_nxt = glyph_r;
    cnt_nxt   = cnt_r;
    retry_nxt = retry_r;
    motor     = MOT_HOLD;
    siren     = 1'b0;
    unique case (mode_r)
      MODE_UNLOCKED: begin
        motor = MOT_RELEASE;
        if (is_star && ev_data.door_closed) begin
          motor     = MOT_HOLD;
          glyph_nxt = GLYPH_L;
        end
      end
      MODE_LOCKED: begin
        if (!ev_data.door_closed) begin
          siren     = 1'b1;
          glyph_nxt = GLYPH_A;
        end else if (is_star) begin
          cnt_nxt   = 3'd0;
          glyph_nxt = GLYPH_P;
        end else begin
          glyph_nxt = GLYPH_L;
        end
      end
      MODE_ENTRY: begin
        if (is_star) begin
          cnt_nxt   = 3'd0;
          glyph_nxt = (cnt_r == 3'd0) ? GLYPH_L : GLYPH_P;
        end else if (last_digit) begin
          cnt_nxt = 3'd0;
          if (code_ok) begin
            retry_nxt = 3'd0;
            motor     = MOT_PULSE;
            glyph_nxt = GLYPH_U;
          end else begin
            retry_nxt = retry_inc;
            glyph_nxt = lockout_hit ? GLYPH_A : GLYPH_E;
          end
        end else if (is_digit) begin
          cnt_nxt   = cnt_r + 3'd1;
          glyph_nxt = digit_glyph(ev_data.digit);
        end
      end
      MODE_LOCKOUT: begin
        glyph_nxt = GLYPH_A;
      end
    endcase
    if (mode_nxt == MODE_LOCKOUT) siren = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_code_r   <= PASS_CODE_RST;
      retry_limit_r <= RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PASS_CODE:   pass_code_r   <= cfg_wdata;
        REG_RETRY_LIMIT: retry_limit_r <= cfg_wdata[2:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_UNLOCKED;
      cnt_r       <= 3'd0;
      retry_r     <= 3'd0;
      glyph_r     <= GLYPH_H;
      out_valid_r <= 1'b0;
    end else begin
      if (ev_pop) begin
        mode_r  <= mode_nxt;
        cnt_r   <= cnt_nxt;
        retry_r <= retry_nxt;
        glyph_r <= glyph_nxt;
      end
      if (ev_pop)         out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload: result register and digit store, no reset
  always_ff @(posedge clk) begin
    if (ev_pop) begin
      out_data_r.motor_cmd        <= motor;
      out_data_r.siren            <= siren;
      out_data_r.display_segments <= glyph_nxt;
      out_data_r.mode             <= mode_nxt;
      out_data_r.digits_entered   <= cnt_nxt;
      out_data_r.retries_used     <= retry_nxt;
    end
    if (ev_pop && store_digit) begin
      ent_r[cnt_r[IDX_W-1:0]] <= ev_data.digit;
    end
  end

  `KLK_ASSERT_NEXT(a_lockout_sticky, in_lockout, in_lockout, "lockout left")
  `KLK_ASSERT_IMPLY(a_count_idle, mode_r != MODE_ENTRY, cnt_r == 3'd0, "digits held outside entry")
  `KLK_ASSERT_IMPLY(a_lockout_siren, out_lockout, out_data_r.siren, "lockout without siren")
  `KLK_ASSERT_ALWAYS(a_count_range, cnt_r <= CNT_LAST, "entry count past code length")

endmodule

`default_nettype wire

FILE: design/keypad_combination_lock_alarm.sv
// Keypad combination lock: one result per key event. An accepted key event is
// registered in the event queue and then in the result register of the
// back-end controller stage, where the result becomes valid; throughput one
// transfer per cycle while out_ready stays high. A two-entry event queue
// separates decode from the controller so each side can stall on its own.
// Synchronous active-low reset: unlocked, glyph H, counters cleared, code 0x1234, retry limit 3.
`default_nettype none

module keypad_combination_lock_alarm #(
  parameter int CODE_DIGITS = klk_pkg::CODE_DIGITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  // configuration write port
  input  wire                      cfg_we,
  input  wire                      cfg_index,
  input  wire  [15:0]              cfg_wdata,
  // key event channel
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  klk_pkg::in_item_t  in_data,
  // result channel
  output logic                     out_valid,
  input  wire                      out_ready,
  output klk_pkg::out_item_t       out_data
);
  import klk_pkg::*;

  ev_item_t ev_in;     // decoded event entering the queue
  ev_item_t ev_head;   // oldest queued event
  logic     q_full;
  logic     q_not_empty;
  logic     q_pop;
  logic     q_push;

  // Input transfer whenever the queue has room; the controller drains it
  // while its output register is empty or being read by the result channel.
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  klk_front u_front (
    .in_data (in_data),
    .ev_data (ev_in)
  );

  klk_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (ev_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (ev_head)
  );

  // Controller: mode machine, counters, code compare, result register
  klk_back #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ev_valid  (q_not_empty),
    .ev_data   (ev_head),
    .ev_pop    (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
